FILE: design/gcdc_pkg.sv
// Package for the gated causal depthwise convolution block.
// Holds sizes, opcodes and the memory port structs; depends on nothing.
package gcdc_pkg;

	localparam int CHANNELS = 1024;
	localparam int MAX_TAPS = 4;
	localparam int SLOTS    = 4;

	// fixed field widths
	localparam int DATA_W = 16;
	localparam int SLOT_W = 2;
	localparam int CHAN_W = 10;
	localparam int TAP_W  = 2;
	localparam int KL_W   = 3;

	localparam logic [KL_W-1:0] KL_RESET = KL_W'(3);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PROC = 1'b1;

	localparam int HIST_N     = MAX_TAPS - 1;
	localparam int HIST_W     = HIST_N * DATA_W;
	localparam int HIST_DEPTH = SLOTS * CHANNELS;
	localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int CHAN_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int WIDX_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int HIDX_W     = (HIST_N > 1) ? $clog2(HIST_N) : 1;
	localparam int TAPS_W     = $clog2(MAX_TAPS + 1);

	// newest product at index 0
	typedef logic [HIST_N-1:0][DATA_W-1:0]   hist_t;
	typedef logic [MAX_TAPS-1:0][DATA_W-1:0] wvec_t;

	typedef struct packed {
		logic               en;
		logic [HIST_AW-1:0] addr;
		hist_t              data;
	} hist_wr_t;

	typedef struct packed {
		logic               en;
		logic [CHAN_AW-1:0] chan;
		logic [WIDX_W-1:0]  tap;
		logic [DATA_W-1:0]  value;
	} weight_wr_t;

endpackage

FILE: design/gcdc_hist_mem.sv
// Product history memory, one word per slot and channel.
// Sweeps itself to zero after reset; uses gcdc_pkg.
module gcdc_hist_mem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [gcdc_pkg::HIST_AW-1:0] rd_addr,
	output gcdc_pkg::hist_t              rd_data,
	input  gcdc_pkg::hist_wr_t           wr,
	output logic                         clr_busy
);

	gcdc_pkg::hist_t                mem_q [gcdc_pkg::HIST_DEPTH];
	gcdc_pkg::hist_t                rd_data_q;
	logic [gcdc_pkg::HIST_AW-1:0]   clr_idx_q;
	logic                           clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + gcdc_pkg::HIST_AW'(1);
			if (clr_idx_q == gcdc_pkg::HIST_AW'(gcdc_pkg::HIST_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_q[clr_idx_q] <= '0;
		end else if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clr_busy = clr_busy_q;

endmodule

FILE: design/gcdc_weight_mem.sv
// Tap weight memory: one lane per tap, indexed by channel.
// A load writes a single lane; uses gcdc_pkg.
module gcdc_weight_mem (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [gcdc_pkg::CHAN_AW-1:0] rd_chan,
	output gcdc_pkg::wvec_t              rd_data,
	input  gcdc_pkg::weight_wr_t         wr
);

	gcdc_pkg::wvec_t rd_data_q;

	for (genvar lane = 0; lane < gcdc_pkg::MAX_TAPS; lane++) begin : g_lane
		logic [gcdc_pkg::DATA_W-1:0] mem_q [gcdc_pkg::CHANNELS];

		always_ff @(posedge clk) begin
			if (wr.en && (wr.tap == gcdc_pkg::WIDX_W'(lane))) begin
				mem_q[wr.chan] <= wr.value;
			end
			if (rd_en) begin
				rd_data_q[lane] <= mem_q[rd_chan];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/gated_causal_depthwise_conv.sv
// Gated short causal depthwise convolution, one channel element per transfer; top level.
// Instantiates gcdc_hist_mem and gcdc_weight_mem; uses gcdc_pkg.
//
// A load transfer (operation 0) writes one tap weight and gives no
// result. A token transfer (operation 1) forms p = b*x (Q4.12, rounded half up and
// saturated), convolves p with the slot/channel history of earlier products using the
// channel's weights, multiplies by c and delivers the rounded, saturated Q4.12 value with
// a flag when either p or the result clipped. first_token zeroes that history before use.
// Sequence: a token occupies the block through an accept step, a memory read / product
// step, a rounding step, a multiply-accumulate step per tap on the single MAC unit (taps
// clamped to 1..MAX_TAPS), the low and high halves of the split c-times-sum multiply,
// and a step that rounds into the output register. That last step waits while an
// earlier result is still unclaimed; the output register lets the next item in as soon as
// it is loaded. After reset the history memory clears itself, one word per slot and
// channel; in_ready stays low meanwhile, config writes are taken. Write kernel_length
// only while the block is idle.
module gated_causal_depthwise_conv (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [gcdc_pkg::KL_W-1:0]   cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        operation,
	input  logic [gcdc_pkg::SLOT_W-1:0] slot,
	input  logic [gcdc_pkg::CHAN_W-1:0] channel,
	input  logic [gcdc_pkg::TAP_W-1:0]  tap,
	input  logic signed [15:0]          weight_value,
	input  logic signed [15:0]          b_value,
	input  logic signed [15:0]          c_value,
	input  logic signed [15:0]          x_value,
	input  logic                        first_token,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [15:0]          gated_value,
	output logic                        saturated
);

	localparam int DW      = gcdc_pkg::DATA_W;
	localparam int PROD_W  = 2 * DW;
	localparam int ACC_W   = PROD_W + $clog2(gcdc_pkg::MAX_TAPS) + 1;
	localparam int LO_W    = 18;
	localparam int PLO_W   = DW + LO_W + 1;
	localparam int PHI_W   = DW + ACC_W - LO_W;
	localparam int GATE_W  = DW + ACC_W;
	localparam int SATIN_W = GATE_W - 24 + 1;
	localparam int TW      = gcdc_pkg::TAPS_W;

	localparam logic signed [SATIN_W-1:0] SAT_MAX   = SATIN_W'(32767);
	localparam logic signed [SATIN_W-1:0] SAT_MIN   = -SATIN_W'(32768);
	localparam logic signed [PROD_W:0]    PROD_HALF = (PROD_W + 1)'(2048);
	localparam logic signed [GATE_W-1:0]  GATE_HALF = GATE_W'(1) << 23;

	// sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PROD  = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_MAC   = 3'd3;
	localparam logic [2:0] ST_GLO   = 3'd4;
	localparam logic [2:0] ST_GHI   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	typedef struct packed {
		logic                     clip;
		logic signed [DW-1:0]     val;
	} sat_t;

	// saturate to signed 16 bits and flag the clip
	function automatic sat_t sat16(input logic signed [SATIN_W-1:0] v);
		sat_t r;
		r.clip = 1'b1;
		if (v > SAT_MAX) begin
			r.val = 16'sh7fff;
		end else if (v < SAT_MIN) begin
			r.val = 16'sh8000;
		end else begin
			r.clip = 1'b0;
			r.val  = v[DW-1:0];
		end
		return r;
	endfunction

	logic [2:0]                     state_q;
	logic [gcdc_pkg::KL_W-1:0]      kl_q;
	logic signed [DW-1:0]           b_q, c_q, x_q, p_q;
	logic                           first_q, clip_q;
	logic [TW-1:0]                  taps_q, k_q;
	logic [gcdc_pkg::HIST_AW-1:0]   haddr_q;
	gcdc_pkg::hist_t                hist_q;
	logic signed [PROD_W-1:0]       raw_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [PLO_W-1:0]        plo_q;
	logic signed [PHI_W-1:0]        phi_q;
	logic                           out_valid_q, sat_q;
	logic signed [DW-1:0]           gated_q;

	logic                           accept, chan_ok, slot_ok, tap_ok, go;
	logic [TW-1:0]                  taps_in;
	logic [gcdc_pkg::HIST_AW-1:0]   haddr_in;
	gcdc_pkg::hist_t                hist_rd, hist_new;
	gcdc_pkg::wvec_t                w_rd;
	gcdc_pkg::hist_wr_t             hist_wr;
	gcdc_pkg::weight_wr_t           w_wr;
	logic                           clr_busy;

	logic                           mac_last;
	logic [TW-1:0]                  hidx_full;
	logic signed [DW-1:0]           w_cur, h_cur;
	logic signed [PROD_W-1:0]       mac_prod;
	logic signed [PROD_W:0]         prod_rnd, prod_sh;
	logic signed [GATE_W-1:0]       gate, gate_rnd, gate_sh;
	sat_t                           p_sat, res_sat;
	logic                           out_load;

	// ---------------- input side ----------------
	assign in_ready = (state_q == ST_IDLE) && !clr_busy;
	assign accept   = in_valid && in_ready;

	assign chan_ok = {1'b0, channel} < (gcdc_pkg::CHAN_W + 1)'(gcdc_pkg::CHANNELS);
	assign slot_ok = {1'b0, slot} < (gcdc_pkg::SLOT_W + 1)'(gcdc_pkg::SLOTS);
	assign tap_ok  = {1'b0, tap} < (gcdc_pkg::TAP_W + 1)'(gcdc_pkg::MAX_TAPS);

	assign go = accept && (operation == gcdc_pkg::OP_PROC) && chan_ok && slot_ok;

	// clamp kernel length into 1..MAX_TAPS
	always_comb begin
		if (kl_q == '0) begin
			taps_in = TW'(1);
		end else if (int'(kl_q) > gcdc_pkg::MAX_TAPS) begin
			taps_in = TW'(gcdc_pkg::MAX_TAPS);
		end else begin
			taps_in = TW'(kl_q);
		end
	end

	assign haddr_in = gcdc_pkg::HIST_AW'(
		gcdc_pkg::HIST_AW'(slot) * gcdc_pkg::HIST_AW'(gcdc_pkg::CHANNELS)
		+ gcdc_pkg::HIST_AW'(channel));

	// weight load: write one tap weight, no result
	always_comb begin
		w_wr.en    = accept && (operation == gcdc_pkg::OP_LOAD) && chan_ok && tap_ok;
		w_wr.chan  = channel[gcdc_pkg::CHAN_AW-1:0];
		w_wr.tap   = tap[gcdc_pkg::WIDX_W-1:0];
		w_wr.value = weight_value;
	end

	gcdc_weight_mem u_weight_mem (
		.clk     (clk),
		.rd_en   (go),
		.rd_chan (channel[gcdc_pkg::CHAN_AW-1:0]),
		.rd_data (w_rd),
		.wr      (w_wr)
	);

	gcdc_hist_mem u_hist_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (go),
		.rd_addr  (haddr_in),
		.rd_data  (hist_rd),
		.wr       (hist_wr),
		.clr_busy (clr_busy)
	);

	// ---------------- datapath ----------------
	// round half up, then clip the product that also enters the history
	assign prod_rnd = $signed({raw_q[PROD_W-1], raw_q}) + PROD_HALF;
	assign prod_sh  = prod_rnd >>> 12;
	assign p_sat    = sat16(SATIN_W'(prod_sh));

	// tap k pairs weight k with the product k steps ahead of the oldest in use;
	// the last tap takes the current product
	assign mac_last  = (k_q == taps_q - TW'(1));
	assign hidx_full = taps_q - TW'(2) - k_q;
	assign w_cur     = $signed(w_rd[k_q[gcdc_pkg::WIDX_W-1:0]]);
	assign h_cur     = mac_last ? p_q : $signed(hist_q[hidx_full[gcdc_pkg::HIDX_W-1:0]]);
	assign mac_prod  = w_cur * h_cur;

	// shift the new product in, drop the oldest
	always_comb begin
		hist_new[0] = p_q;
		for (int i = 1; i < gcdc_pkg::HIST_N; i++) begin
			hist_new[i] = hist_q[i-1];
		end
	end

	always_comb begin
		hist_wr.en   = (state_q == ST_GLO);
		hist_wr.addr = haddr_q;
		hist_wr.data = hist_new;
	end

	// recombine the split c * sum product, round at bit 24
	assign gate     = (GATE_W'(phi_q) <<< LO_W) + GATE_W'(plo_q);
	assign gate_rnd = gate + GATE_HALF;
	assign gate_sh  = gate_rnd >>> 24;
	assign res_sat  = sat16($signed(gate_sh[SATIN_W-1:0]));

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kl_q    <= gcdc_pkg::KL_RESET;
		end else begin
			if (cfg_wr_en) begin
				kl_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (go) begin
						state_q <= ST_PROD;
					end
				end
				ST_PROD:  state_q <= ST_ROUND;
				ST_ROUND: state_q <= ST_MAC;
				ST_MAC: begin
					if (mac_last) begin
						state_q <= ST_GLO;
					end
				end
				ST_GLO: state_q <= ST_GHI;
				ST_GHI: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// work registers, no reset needed
	always_ff @(posedge clk) begin
		if (go) begin
			b_q     <= b_value;
			c_q     <= c_value;
			x_q     <= x_value;
			first_q <= first_token;
			taps_q  <= taps_in;
			haddr_q <= haddr_in;
		end
		case (state_q)
			ST_PROD: begin
				raw_q  <= b_q * x_q;
				hist_q <= first_q ? '0 : hist_rd;
			end
			ST_ROUND: begin
				p_q    <= p_sat.val;
				clip_q <= p_sat.clip;
				acc_q  <= '0;
				k_q    <= '0;
			end
			ST_MAC: begin
				acc_q <= acc_q + ACC_W'(mac_prod);
				k_q   <= k_q + TW'(1);
			end
			ST_GLO:  plo_q <= c_q * $signed({1'b0, acc_q[LO_W-1:0]});
			ST_GHI:  phi_q <= c_q * $signed(acc_q[ACC_W-1:LO_W]);
			default: ;
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			gated_q <= res_sat.val;
			sat_q   <= clip_q | res_sat.clip;
		end
	end

	assign out_valid   = out_valid_q;
	assign gated_value = gated_q;
	assign saturated   = sat_q;

endmodule

FILE: dv/gcdc_result_checker.sv
// Result checker for gated_causal_depthwise_conv: watches the config port and both
// transfer channels, predicts every token result and compares it when it is delivered.
// Depends on gcdc_pkg.
`timescale 1ns / 1ps

module gcdc_result_checker
	import gcdc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [KL_W-1:0]      cfg_wr_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 operation,
	input  logic [SLOT_W-1:0]    slot,
	input  logic [CHAN_W-1:0]    channel,
	input  logic [TAP_W-1:0]     tap,
	input  logic signed [15:0]   weight_value,
	input  logic signed [15:0]   b_value,
	input  logic signed [15:0]   c_value,
	input  logic signed [15:0]   x_value,
	input  logic                 first_token,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic signed [15:0]   gated_value,
	input  logic                 saturated,
	output int                   failures,
	output int                   outstanding,
	output int                   results_checked
);

	localparam longint Q_MAX = 32767;
	localparam longint Q_MIN = -32768;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     clip;
		int                       seq;
	} gated_result_t;

	// product history per slot/channel row, newest first; starts cleared
	bit signed [DATA_W-1:0] prod_hist [HIST_DEPTH][HIST_N];
	bit signed [DATA_W-1:0] tap_w [CHANNELS][MAX_TAPS];
	logic [KL_W-1:0]        kernel_len = KL_RESET;
	gated_result_t          expected_q [$];
	int                     token_seq = 0;
	int                     fail_tally = 0;
	int                     compared = 0;

	task automatic report_mismatch(string msg);
		fail_tally++;
		$display("%0t ns  MISMATCH  %s", $time, msg);
	endtask

	// round half up at bit sh, then clip to 16 bits
	function automatic longint round_sat16(longint v, int sh, inout bit clip);
		longint r;
		r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
		if (r > Q_MAX) begin
			clip = 1'b1;
			r = Q_MAX;
		end else if (r < Q_MIN) begin
			clip = 1'b1;
			r = Q_MIN;
		end
		return r;
	endfunction

	function automatic gated_result_t conv_token(logic [SLOT_W-1:0] s, logic [CHAN_W-1:0] ch,
		logic signed [15:0] b, logic signed [15:0] c, logic signed [15:0] x, logic first);
		gated_result_t res;
		int            row;
		int            taps;
		bit            clip;
		longint        prod;
		longint        acc;
		clip = 1'b0;
		row = int'(s) * CHANNELS + int'(ch);
		taps = (kernel_len < 1) ? 1 : (kernel_len > MAX_TAPS) ? MAX_TAPS : int'(kernel_len);
		if (first) begin
			for (int k = 0; k < HIST_N; k++)
				prod_hist[row][k] = '0;
		end
		prod = round_sat16(longint'(b) * longint'(x), 12, clip);
		acc = longint'(tap_w[ch][taps - 1]) * prod;
		for (int k = 0; k < taps - 1; k++)
			acc += longint'(tap_w[ch][k]) * longint'(prod_hist[row][taps - 2 - k]);
		res.value = DATA_W'(round_sat16(longint'(c) * acc, 24, clip));
		for (int k = HIST_N - 1; k > 0; k--)
			prod_hist[row][k] = prod_hist[row][k - 1];
		prod_hist[row][0] = DATA_W'(prod);
		res.clip = clip;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		gated_result_t want;
		gated_result_t got;
		if (!arst_n) begin
			kernel_len = KL_RESET;
		end else begin
			if (cfg_wr_en)
				kernel_len = cfg_wr_data;
			if (in_valid && in_ready) begin
				if (operation == OP_LOAD) begin
					tap_w[channel][tap] = weight_value;
				end else begin
					got = conv_token(slot, channel, b_value, c_value, x_value, first_token);
					got.seq = token_seq++;
					expected_q.push_back(got);
				end
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("result %0d (sat %0b) with nothing expected",
						gated_value, saturated));
				end else begin
					want = expected_q.pop_front();
					compared++;
					if (gated_value !== want.value)
						report_mismatch($sformatf("token %0d: gated_value %0d, want %0d",
							want.seq, gated_value, want.value));
					if (saturated !== want.clip)
						report_mismatch($sformatf("token %0d: saturated %b, want %b",
							want.seq, saturated, want.clip));
				end
			end
		end
		outstanding     <= expected_q.size();
		failures        <= fail_tally;
		results_checked <= compared;
	end

endmodule

FILE: dv/tb_gated_causal_depthwise_conv.sv
// Top-level bench for gated_causal_depthwise_conv: drives weight loads, token elements and
// kernel_length writes, stalls the result side, and reports the verdict.
// Depends on gcdc_pkg, the block itself and gcdc_result_checker.
`timescale 1ns / 1ps

module tb_gated_causal_depthwise_conv;
	import gcdc_pkg::*;

	localparam int RUN_LIMIT     = 1_000_000;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 115;
	localparam int SETTLE_CYCLES = 16;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_wr_en;
	logic [KL_W-1:0]          cfg_wr_data;
	logic                     in_valid;
	logic                     in_ready;
	logic                     operation;
	logic [SLOT_W-1:0]        slot;
	logic [CHAN_W-1:0]        channel;
	logic [TAP_W-1:0]         tap;
	logic signed [15:0]       weight_value;
	logic signed [15:0]       b_value;
	logic signed [15:0]       c_value;
	logic signed [15:0]       x_value;
	logic                     first_token;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [15:0]       gated_value;
	logic                     saturated;

	int                       failures;
	int                       outstanding;
	int                       results_checked;
	int                       cycles;
	int                       tokens_sent = 0;
	int                       loads_sent = 0;
	int                       kl_writes = 0;

	// channels get tokens only once every tap weight has been loaded
	bit [MAX_TAPS-1:0]        taps_loaded [CHANNELS];
	bit                       chan_ready [CHANNELS];
	int                       ready_chans [$];
	bit                       no_gaps = 1'b0;
	logic [KL_W-1:0]          kl_plan [PHASES];

	always #2 clk = ~clk;

	gated_causal_depthwise_conv dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.slot         (slot),
		.channel      (channel),
		.tap          (tap),
		.weight_value (weight_value),
		.b_value      (b_value),
		.c_value      (c_value),
		.x_value      (x_value),
		.first_token  (first_token),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.gated_value  (gated_value),
		.saturated    (saturated)
	);

	gcdc_result_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.slot            (slot),
		.channel         (channel),
		.tap             (tap),
		.weight_value    (weight_value),
		.b_value         (b_value),
		.c_value         (c_value),
		.x_value         (x_value),
		.first_token     (first_token),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.gated_value     (gated_value),
		.saturated       (saturated),
		.failures        (failures),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	// Modest Q4.12 values most often, a good share of full-range ones (which can clip the
	// product), and the rails themselves or +-1.0.
	function automatic logic signed [15:0] pick_q412();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return DATA_W'(int'($urandom_range(0, 16384)) - 8192);
		if (r < 80)
			return DATA_W'($urandom);
		case ($urandom_range(0, 3))
			0:       return 16'sh8000;
			1:       return 16'sh7fff;
			2:       return 16'sh1000;
			default: return 16'shf000;
		endcase
	endfunction

	// Idle length: mostly none or short, now and then a long one.
	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Present one item and hold it until the transfer. Valid stays high into the next
	// item when no gap follows, so it is never dropped and raised in the same step.
	task automatic send_item(logic op, logic [SLOT_W-1:0] s, logic [CHAN_W-1:0] ch,
		logic [TAP_W-1:0] t, logic signed [15:0] w, logic signed [15:0] b,
		logic signed [15:0] c, logic signed [15:0] x, logic ft);
		int gap;
		operation    <= op;
		slot         <= s;
		channel      <= ch;
		tap          <= t;
		weight_value <= w;
		b_value      <= b;
		c_value      <= c;
		x_value      <= x;
		first_token  <= ft;
		in_valid     <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (op == OP_LOAD) begin
			loads_sent++;
			taps_loaded[ch][t] = 1'b1;
			if (&taps_loaded[ch] && !chan_ready[ch]) begin
				chan_ready[ch] = 1'b1;
				ready_chans.push_back(int'(ch));
			end
		end else begin
			tokens_sent++;
		end
		gap = no_gaps ? 0 : gap_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Loads carry random junk in the token fields so every bit still toggles.
	task automatic send_load(int ch, int t, logic signed [15:0] w);
		send_item(OP_LOAD, SLOT_W'($urandom), CHAN_W'(ch), TAP_W'(t), w,
			DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom), 1'($urandom));
	endtask

	task automatic send_token(int s, int ch, logic signed [15:0] b, logic signed [15:0] c,
		logic signed [15:0] x, logic ft);
		send_item(OP_PROC, SLOT_W'(s), CHAN_W'(ch), TAP_W'($urandom), pick_q412(),
			b, c, x, ft);
	endtask

	// Drop valid, wait for every expected result, then let the pipe drain fully.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: ready bursts of random length, occasionally long clean stretches,
	// separated by the same gap mix as the sender.
	initial begin : result_stalls
		int gap;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(100, 300)) @(posedge clk);
			else
				repeat ($urandom_range(1, 40)) @(posedge clk);
			gap = gap_cycles();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Watchdog: covers the history clearing pass after reset with a wide margin.
	initial begin : watchdog
		cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles, %0d results still outstanding",
			cycles, outstanding);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int r;
		int ch;
		int n;
		int pick;
		int sent;

		// extremes first, then a mix; out-of-range lengths clamp to 1 and MAX_TAPS
		kl_plan = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4, 3'd1};

		arst_n       <= 1'b0;
		cfg_wr_en    <= 1'b0;
		cfg_wr_data  <= KL_RESET;
		in_valid     <= 1'b0;
		operation    <= OP_LOAD;
		slot         <= '0;
		channel      <= '0;
		tap          <= '0;
		weight_value <= '0;
		b_value      <= '0;
		c_value      <= '0;
		x_value      <= '0;
		first_token  <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset kernel length. Weights at the rails on the two
		// end channels, then tokens that clip the product both ways, hit the half-up
		// rounding point from each side, zero the c gate and restart a history.
		send_load(0, 0, 16'sh1000);
		send_load(0, 1, 16'sh8000);
		send_load(0, 2, 16'sh7fff);
		send_load(0, 3, 16'sh0800);
		send_load(CHANNELS - 1, 0, 16'shf000);
		send_load(CHANNELS - 1, 1, 16'sh0001);
		send_load(CHANNELS - 1, 2, 16'sh1000);
		send_load(CHANNELS - 1, 3, 16'sh8000);
		send_token(0, 0, 16'sh1000, 16'sh1000, 16'sh1000, 1'b1);
		send_token(0, 0, 16'sh8000, 16'sh1000, 16'sh8000, 1'b0);
		send_token(0, 0, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b0);
		send_token(3, 0, 16'sh0001, 16'sh1000, 16'sh0800, 1'b1);
		send_token(3, 0, 16'shffff, 16'sh1000, 16'sh0800, 1'b0);
		send_token(3, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
		send_token(0, 0, 16'sh1000, 16'sh0000, 16'sh1000, 1'b1);
		send_token(1, CHANNELS - 1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
		send_token(1, CHANNELS - 1, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
		send_token(2, CHANNELS - 1, 16'sh0000, 16'sh1000, 16'sh0000, 1'b1);
		send_token(1, CHANNELS - 1, 16'sh1000, 16'shf000, 16'sh1000, 1'b0);
		send_token(2, CHANNELS - 1, 16'sh7fff, 16'sh0001, 16'shffff, 1'b0);

		for (int ph = 0; ph < PHASES; ph++) begin
			// kernel_length only changes with the block idle
			settle();
			cfg_wr_en   <= 1'b1;
			cfg_wr_data <= kl_plan[ph];
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			kl_writes++;
			// every third phase streams back to back on the input side
			no_gaps = (ph % 3 == 2);

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					// bring up a fresh channel: all taps in order
					ch = $urandom_range(0, CHANNELS - 1);
					for (int t = 0; t < MAX_TAPS; t++)
						send_load(ch, t, pick_q412());
					sent += MAX_TAPS;
				end else if (r < 10) begin
					// rewrite a live weight, or a stray load anywhere
					if (r < 6)
						ch = ready_chans[$urandom_range(0, ready_chans.size() - 1)];
					else
						ch = $urandom_range(0, CHANNELS - 1);
					send_load(ch, $urandom_range(0, MAX_TAPS - 1), pick_q412());
					sent++;
				end else begin
					// favor the newest channels so slot histories fill up
					n = ready_chans.size();
					if ($urandom_range(0, 9) < 7)
						pick = n - 1 - $urandom_range(0, (n > 6) ? 5 : n - 1);
					else
						pick = $urandom_range(0, n - 1);
					send_token($urandom_range(0, SLOTS - 1), ready_chans[pick],
						pick_q412(), pick_q412(), pick_q412(), $urandom_range(0, 99) < 8);
					sent++;
				end
			end
		end

		settle();
		$display("Covered %0d token elements and %0d weight loads across %0d kernel_length writes",
			tokens_sent, loads_sent, kl_writes);
		$display("Compared %0d results, %0d mismatches", results_checked, failures);
		if (failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
